@@ rtl/noise_gate_attack_hold_decay_unit_macros.svh @@
// Assertion helpers for the noise gate block.
// NGAHD_CHECK: implication in the same cycle.
// NGAHD_CHECK_NEXT: implication in the next cycle.
`ifndef NOISE_GATE_ATTACK_HOLD_DECAY_UNIT_MACROS_SVH
`define NOISE_GATE_ATTACK_HOLD_DECAY_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define NGAHD_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("noise gate check failed");
`define NGAHD_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("noise gate check failed");
`else
`define NGAHD_CHECK(label, ante, cons)
`define NGAHD_CHECK_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/ngahd_pkg.sv @@
`default_nettype none

package ngahd_pkg;

  // gate phases
  localparam logic [1:0] PH_CLOSED = 2'd0;
  localparam logic [1:0] PH_ATTACK = 2'd1;
  localparam logic [1:0] PH_OPEN   = 2'd2;
  localparam logic [1:0] PH_DECAY  = 2'd3;

  // register indexes (byte address 4*i)
  localparam int unsigned ADDR_WIDTH = 5;
  localparam logic [2:0] REG_ENABLE    = 3'd0;
  localparam logic [2:0] REG_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_ATTACK    = 3'd2;
  localparam logic [2:0] REG_HOLD      = 3'd3;
  localparam logic [2:0] REG_DECAY     = 3'd4;
  localparam logic [2:0] REG_FLOOR     = 3'd5;

  // front-to-back queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_WIDTH  = 2;
  localparam int unsigned QCNT_WIDTH  = 3;

  typedef struct packed {
    logic [1:0] phase;
    logic       gain_zero;
    logic       gain_full;
  } ngahd_status_t;

endpackage

`default_nettype wire

@@ rtl/ngahd_front.sv @@
`default_nettype none

module ngahd_front
  import ngahd_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH   = 24,
  parameter int unsigned GAIN_FRAC_BITS = 23,
  parameter int unsigned HOLD_WIDTH     = 20
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            enable_i,
  input  logic        [SAMPLE_WIDTH-1:0]  threshold_i,
  input  logic        [GAIN_FRAC_BITS:0]  attack_step_i,
  input  logic        [HOLD_WIDTH-1:0]    hold_length_i,
  input  logic        [GAIN_FRAC_BITS:0]  decay_step_i,
  input  logic                            push_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  sample_i,
  output logic        [GAIN_FRAC_BITS:0]  gain_o,
  output logic        [1:0]               phase_o,
  output ngahd_status_t                   status_o
);

  localparam int unsigned GW = GAIN_FRAC_BITS + 1;
  localparam logic [GW-1:0] GAIN_ONE = {1'b1, {GAIN_FRAC_BITS{1'b0}}};

  logic [1:0]              phase_q, phase_d;
  logic [GW-1:0]           gain_q, gain_d;
  logic [HOLD_WIDTH-1:0]   hold_q, hold_d;

  logic [SAMPLE_WIDTH:0]   neg_ext;
  logic [SAMPLE_WIDTH-1:0] mag;
  logic                    loud;
  logic [GW:0]             gain_sum;

  assign neg_ext  = {1'b0, ~sample_i} + {{SAMPLE_WIDTH{1'b0}}, 1'b1};
  assign mag      = sample_i[SAMPLE_WIDTH-1] ? neg_ext[SAMPLE_WIDTH-1:0] : sample_i;
  assign loud     = mag >= threshold_i;
  assign gain_sum = {1'b0, gain_q} + {1'b0, attack_step_i};

  always_comb begin
    phase_d = phase_q;
    gain_d  = gain_q;
    hold_d  = hold_q;

    case (phase_q)
      PH_CLOSED, PH_DECAY: begin
        if (loud) phase_d = PH_ATTACK;
      end
      PH_OPEN: begin
        if (loud) begin
          hold_d = hold_length_i;
        end else if (hold_q == '0) begin
          phase_d = PH_DECAY;
        end else begin
          hold_d = hold_q - HOLD_WIDTH'(1);
        end
      end
      default: ;
    endcase

    // ramp in the same sample as the phase change
    case (phase_d)
      PH_DECAY: begin
        if (decay_step_i >= gain_q) begin
          gain_d  = '0;
          phase_d = PH_CLOSED;
        end else begin
          gain_d = gain_q - decay_step_i;
        end
      end
      PH_ATTACK: begin
        if (gain_sum >= {1'b0, GAIN_ONE}) begin
          gain_d  = GAIN_ONE;
          phase_d = PH_OPEN;
          hold_d  = hold_length_i;
        end else begin
          gain_d = gain_sum[GW-1:0];
        end
      end
      default: ;
    endcase
  end

  // gain handed to the back: closed uses floor alone, attack and decay the ramped gain, open and bypass pass through
  always_comb begin
    if (!enable_i) begin
      gain_o  = GAIN_ONE;
      phase_o = phase_q;
    end else begin
      phase_o = phase_d;
      case (phase_d)
        PH_CLOSED: gain_o = '0;
        PH_OPEN:   gain_o = GAIN_ONE;
        default:   gain_o = gain_d;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CLOSED;
      gain_q  <= '0;
      hold_q  <= '0;
    end else if (push_i && enable_i) begin
      phase_q <= phase_d;
      gain_q  <= gain_d;
      hold_q  <= hold_d;
    end
  end

  assign status_o.phase     = phase_q;
  assign status_o.gain_zero = gain_q == '0;
  assign status_o.gain_full = gain_q == GAIN_ONE;

endmodule

`default_nettype wire

@@ rtl/ngahd_queue.sv @@
`default_nettype none

module ngahd_queue
  import ngahd_pkg::*;
#(
  parameter int unsigned WIDTH = 50
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0]      mem_q [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_WIDTH-1:0] cnt_q;
  logic                  do_push, do_pop;

  assign full_o  = cnt_q == QCNT_WIDTH'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_WIDTH'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + QPTR_WIDTH'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + QCNT_WIDTH'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_WIDTH'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/ngahd_back.sv @@
`default_nettype none

module ngahd_back
  import ngahd_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH   = 24,
  parameter int unsigned GAIN_FRAC_BITS = 23
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic        [GAIN_FRAC_BITS:0]  floor_gain_i,
  input  logic                            q_empty_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  q_sample_i,
  input  logic        [GAIN_FRAC_BITS:0]  q_gain_i,
  input  logic        [1:0]               q_phase_i,
  output logic                            q_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]  sample_out_o,
  output logic        [1:0]               phase_out_o
);

  localparam int unsigned GW = GAIN_FRAC_BITS + 1;
  localparam int unsigned PW = SAMPLE_WIDTH + GW + 1;
  localparam logic [GW-1:0] GAIN_ONE = {1'b1, {GAIN_FRAC_BITS{1'b0}}};

  logic                    adv;
  logic [GW-1:0]           fl, one_minus_fl, eff;

  logic                    a_vld_q;
  logic [SAMPLE_WIDTH-1:0] a_sample_q;
  logic [1:0]              a_phase_q;
  logic [2*GW-1:0]         a_prod_q;

  logic                    b_vld_q;
  logic [1:0]              b_phase_q;
  logic signed [PW-1:0]    b_prod_q;

  logic                    o_vld_q;
  logic [SAMPLE_WIDTH-1:0] o_sample_q;
  logic [1:0]              o_phase_q;

  logic signed [PW-1:0]    s_ext, eff_ext;

  // whole pipe moves when the output register is free or being taken
  assign adv     = !o_vld_q || !out_stall_i;
  assign q_pop_o = adv && !q_empty_i;

  assign fl           = (floor_gain_i > GAIN_ONE) ? GAIN_ONE : floor_gain_i;
  assign one_minus_fl = GAIN_ONE - fl;
  assign eff          = fl + a_prod_q[GAIN_FRAC_BITS +: GW];

  assign s_ext   = {{(GW+1){a_sample_q[SAMPLE_WIDTH-1]}}, a_sample_q};
  assign eff_ext = {{(SAMPLE_WIDTH+1){1'b0}}, eff};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= !q_empty_i;
      b_vld_q <= a_vld_q;
      o_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_sample_q <= q_sample_i;
      a_phase_q  <= q_phase_i;
      a_prod_q   <= {{GW{1'b0}}, q_gain_i} * {{GW{1'b0}}, one_minus_fl};
      b_phase_q  <= a_phase_q;
      b_prod_q   <= s_ext * eff_ext;
      // arithmetic shift rounds toward minus infinity
      o_sample_q <= b_prod_q[GAIN_FRAC_BITS +: SAMPLE_WIDTH];
      o_phase_q  <= b_phase_q;
    end
  end

  assign out_valid_o  = o_vld_q;
  assign sample_out_o = o_sample_q;
  assign phase_out_o  = o_phase_q;

endmodule

`default_nettype wire

@@ rtl/noise_gate_attack_hold_decay_unit.sv @@
// Noise gate with attack, hold and decay ramps.
// After acceptance a sample passes the queue, then the product, scale and output registers.
// Throughput: one sample per cycle while the queue is not full; the gate state updates at accept
// when enabled, and a 4-entry queue lets input keep flowing while the output stalls.
// Reset: phase closed, gain and hold count zero, queue and pipeline empty,
// registers enable 0, threshold 0, steps 1.0, hold 0, floor 0.
`default_nettype none
`include "noise_gate_attack_hold_decay_unit_macros.svh"

module noise_gate_attack_hold_decay_unit
  import ngahd_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH   = 24,
  parameter int unsigned GAIN_FRAC_BITS = 23,
  parameter int unsigned HOLD_WIDTH     = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic        [ADDR_WIDTH-1:0]   paddr,
  input  logic        [31:0]             pwdata,
  output logic        [31:0]             prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  output logic        [1:0]              phase_out_o
);

  localparam int unsigned GW = GAIN_FRAC_BITS + 1;
  localparam int unsigned QW = SAMPLE_WIDTH + GW + 2;
  localparam logic [GW-1:0] GAIN_ONE = {1'b1, {GAIN_FRAC_BITS{1'b0}}};

  logic                    enable_q;
  logic [SAMPLE_WIDTH-1:0] threshold_q;
  logic [GW-1:0]           attack_q;
  logic [HOLD_WIDTH-1:0]   hold_q;
  logic [GW-1:0]           decay_q;
  logic [GW-1:0]           floor_q;

  logic                    wr_en;
  logic [2:0]              reg_idx;

  logic                    push;
  logic                    q_full, q_empty, q_pop;
  logic [GW-1:0]           f_gain;
  logic [1:0]              f_phase;
  logic [QW-1:0]           q_wdata, q_rdata;
  ngahd_status_t           st;

  // ---------------- config port ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_WIDTH-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      threshold_q <= '0;
      attack_q    <= GAIN_ONE;
      hold_q      <= '0;
      decay_q     <= GAIN_ONE;
      floor_q     <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ENABLE:    enable_q    <= pwdata[0];
        REG_THRESHOLD: threshold_q <= pwdata[SAMPLE_WIDTH-1:0];
        REG_ATTACK:    attack_q    <= pwdata[GW-1:0];
        REG_HOLD:      hold_q      <= pwdata[HOLD_WIDTH-1:0];
        REG_DECAY:     decay_q     <= pwdata[GW-1:0];
        REG_FLOOR:     floor_q     <= pwdata[GW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ENABLE:    prdata = {31'd0, enable_q};
      REG_THRESHOLD: prdata = 32'(threshold_q);
      REG_ATTACK:    prdata = 32'(attack_q);
      REG_HOLD:      prdata = 32'(hold_q);
      REG_DECAY:     prdata = 32'(decay_q);
      REG_FLOOR:     prdata = 32'(floor_q);
      default:       prdata = '0;
    endcase
  end

  // ---------------- front ----------------
  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  ngahd_front #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS),
    .HOLD_WIDTH    (HOLD_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .enable_i     (enable_q),
    .threshold_i  (threshold_q),
    .attack_step_i(attack_q),
    .hold_length_i(hold_q),
    .decay_step_i (decay_q),
    .push_i       (push),
    .sample_i     (sample_in_i),
    .gain_o       (f_gain),
    .phase_o      (f_phase),
    .status_o     (st)
  );

  assign q_wdata = {sample_in_i, f_gain, f_phase};

  ngahd_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  // ---------------- back ----------------
  ngahd_back #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .floor_gain_i(floor_q),
    .q_empty_i   (q_empty),
    .q_sample_i  (q_rdata[QW-1 -: SAMPLE_WIDTH]),
    .q_gain_i    (q_rdata[2 +: GW]),
    .q_phase_i   (q_rdata[1:0]),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_out_o(sample_out_o),
    .phase_out_o (phase_out_o)
  );

  // ---------------- checks ----------------
  `NGAHD_CHECK(a_open_gain_full, st.phase == PH_OPEN, st.gain_full)
  `NGAHD_CHECK(a_closed_gain_zero, st.phase == PH_CLOSED, st.gain_zero)
  `NGAHD_CHECK_NEXT(a_bypass_keeps_state, push && !enable_q, $stable(st))

endmodule

`default_nettype wire

@@ test/noise_gate_attack_hold_decay_unit_checker.sv @@
`timescale 1ns / 1ps

module noise_gate_attack_hold_decay_unit_checker
  import ngahd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic signed [23:0]    sample_in_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic signed [23:0]    sample_out_i,
  input  logic [1:0]            phase_out_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o
);

  localparam longint GAIN_ONE = 64'd1 << 23;

  typedef struct packed {
    logic [23:0] smp;
    logic [1:0]  ph;
  } gated_beat_t;

  // register shadow
  logic        gate_en;
  logic [23:0] thr_r;
  logic [23:0] atk_r;
  logic [19:0] hold_len_r;
  logic [23:0] dec_r;
  logic [23:0] floor_r;

  // gate state
  logic [1:0]  gate_ph;
  longint      gain_lvl;
  logic [19:0] hold_cnt;

  gated_beat_t gated_due[$];

  function automatic gated_beat_t gate_sample(input logic signed [23:0] s);
    gated_beat_t r;
    longint      sv;
    longint      mag;
    longint      fl;
    longint      eff;
    longint      y;
    logic        loud;
    sv = longint'(s);
    r.smp = s;
    r.ph = gate_ph;
    if (gate_en) begin
      mag = (sv < 0) ? -sv : sv;
      loud = mag >= longint'(thr_r);
      fl = (longint'(floor_r) > GAIN_ONE) ? GAIN_ONE : longint'(floor_r);
      case (gate_ph)
        PH_CLOSED, PH_DECAY: begin
          if (loud) gate_ph = PH_ATTACK;
        end
        PH_OPEN: begin
          if (loud) hold_cnt = hold_len_r;
          else if (hold_cnt == 0) gate_ph = PH_DECAY;
          else hold_cnt = hold_cnt - 20'd1;
        end
        default: ;
      endcase
      case (gate_ph)
        PH_CLOSED: y = (sv * fl) >>> 23;
        PH_OPEN:   y = sv;
        default: begin
          if (gate_ph == PH_DECAY) begin
            if (longint'(dec_r) >= gain_lvl) begin
              gain_lvl = 0;
              gate_ph = PH_CLOSED;
            end else begin
              gain_lvl = gain_lvl - longint'(dec_r);
            end
          end else begin
            gain_lvl = gain_lvl + longint'(atk_r);
            if (gain_lvl >= GAIN_ONE) begin
              gain_lvl = GAIN_ONE;
              gate_ph = PH_OPEN;
              hold_cnt = hold_len_r;
            end
          end
          eff = fl + ((gain_lvl * (GAIN_ONE - fl)) >>> 23);
          y = (sv * eff) >>> 23;
        end
      endcase
      r.smp = y[23:0];
      r.ph = gate_ph;
    end
    return r;
  endfunction

  task automatic flag(input string what, input longint want, input longint got);
    if (fail_count_o < 10)
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    gated_beat_t want;
    if (!rst_ni) begin
      gate_en = 1'b0;
      thr_r = '0;
      atk_r = 24'h800000;
      hold_len_r = '0;
      dec_r = 24'h800000;
      floor_r = '0;
      gate_ph = PH_CLOSED;
      gain_lvl = 0;
      hold_cnt = '0;
      gated_due.delete();
      fail_count_o = 0;
      pending_o = 0;
      checked_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_WIDTH-1:2])
          REG_ENABLE:    gate_en = pwdata[0];
          REG_THRESHOLD: thr_r = pwdata[23:0];
          REG_ATTACK:    atk_r = pwdata[23:0];
          REG_HOLD:      hold_len_r = pwdata[19:0];
          REG_DECAY:     dec_r = pwdata[23:0];
          REG_FLOOR:     floor_r = pwdata[23:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) gated_due.push_back(gate_sample(sample_in_i));
      if (out_valid_i && !out_stall_i) begin
        checked_o++;
        if (gated_due.size() == 0) begin
          flag("unexpected beat, sample_out", 0, sample_out_i);
        end else begin
          want = gated_due.pop_front();
          if (sample_out_i !== want.smp) flag("sample_out", want.smp, sample_out_i);
          if (phase_out_i !== want.ph) flag("phase_out", want.ph, phase_out_i);
        end
      end
      pending_o = gated_due.size();
    end
  end

endmodule

@@ test/noise_gate_attack_hold_decay_unit_tb.sv @@
`timescale 1ns / 1ps

module noise_gate_attack_hold_decay_unit_tb;
  import ngahd_pkg::*;

  localparam int SETS      = 14;
  localparam int SET_ITEMS = 120;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic signed [23:0]    sample_in_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic signed [23:0]    sample_out_o;
  logic [1:0]            phase_out_o;

  logic        in_beat = 1'b0;
  logic        out_beat = 1'b0;
  bit          steady = 1'b0;   // no idling on either side
  int          stall_left = 0;
  logic [23:0] thr_now = '0;
  int          fail_count;
  int          pending;
  int          checked;
  int          n_sent = 0;
  int          n_writes = 0;

  logic [23:0] bypass_walk [4] = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF};
  // closed -> attack -> open -> hold -> decay -> re-attack -> open -> decay -> closed
  logic [23:0] gate_walk [21] = '{
    24'h000100, 24'hF00001, 24'h100000, 24'hF00000, 24'h7FFFFF, 24'h800000,
    24'h000001, 24'hFFFFFF, 24'h0FFFFF, 24'h000005, 24'h200000, 24'h000000,
    24'h000000, 24'h123456, 24'hEDCBAA, 24'h000002, 24'hFFFFFE, 24'h000003,
    24'h000000, 24'h0FFFFF, 24'hF00001
  };

  noise_gate_attack_hold_decay_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .phase_out_o  (phase_out_o)
  );

  noise_gate_attack_hold_decay_unit_checker gate_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .sample_in_i  (sample_in_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_i (sample_out_o),
    .phase_out_i  (phase_out_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    in_beat <= in_valid_i && !in_stall_o;
    out_beat <= out_valid_o && !out_stall_i;
  end

  // result side: after each beat, stall for a freshly drawn number of cycles, none when steady
  always @(negedge clk_i) begin
    if (out_beat) stall_left = steady ? 0 : $urandom_range(0, 6);
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic logic [23:0] loud_sample();
    logic [23:0] mag;
    if (thr_now > 24'h800000) return 24'($urandom);
    mag = thr_now + 24'($urandom_range(0, 24'h800000 - thr_now));
    if (mag == 24'h800000 || $urandom_range(0, 1)) return -mag;
    return mag;
  endfunction

  function automatic logic [23:0] quiet_sample();
    logic [23:0] top;
    logic [23:0] mag;
    if (thr_now == 0) return '0;
    top = (thr_now > 24'h800000) ? 24'h7FFFFF : thr_now - 24'd1;
    mag = 24'($urandom_range(0, top));
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  task automatic send_sample(input logic [23:0] s);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_in_i <= s;
    do @(negedge clk_i); while (!in_beat);
    n_sent++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    n_writes++;
  endtask

  task automatic load_set(input bit en, input logic [23:0] thr, input logic [23:0] atk,
                          input logic [19:0] hld, input logic [23:0] dec,
                          input logic [23:0] flr);
    write_reg(REG_ENABLE, {31'd0, en});
    write_reg(REG_THRESHOLD, {8'd0, thr});
    write_reg(REG_ATTACK, {8'd0, atk});
    write_reg(REG_HOLD, {12'd0, hld});
    write_reg(REG_DECAY, {8'd0, dec});
    write_reg(REG_FLOOR, {8'd0, flr});
    thr_now = thr;
  endtask

  // wait out every expected beat plus the pipeline depth
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  initial begin
    logic [23:0] thr;
    logic [23:0] atk;
    logic [19:0] hld;
    logic [23:0] dec;
    logic [23:0] flr;
    logic [23:0] shot;
    bit          en;
    int          kind;
    int          len;
    int          k;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // out of reset the gate is bypassed
    foreach (bypass_walk[i]) send_sample(bypass_walk[i]);
    drain();
    load_set(1'b1, 24'h100000, 24'h200000, 20'd2, 24'h300000, 24'h100000);
    foreach (gate_walk[i]) send_sample(gate_walk[i]);

    for (int p = 0; p < SETS; p++) begin
      drain();
      en = !(p == 4 || p == 11);
      case ($urandom_range(0, 3))
        0:       thr = 24'($urandom_range(0, 255));
        3:       thr = 24'($urandom_range(0, 24'hFFFFFF));
        default: thr = 24'($urandom_range(24'h010000, 24'h400000));
      endcase
      atk = ($urandom_range(0, 4) == 0) ? 24'($urandom_range(0, 24'hFFFFFF))
                                        : 24'($urandom_range(24'h020000, 24'h800000));
      dec = ($urandom_range(0, 4) == 0) ? 24'($urandom_range(0, 24'hFFFFFF))
                                        : 24'($urandom_range(24'h020000, 24'h800000));
      hld = 20'($urandom_range(0, 24));
      flr = 24'($urandom_range(0, 24'h800000));
      case (p)
        0: thr = '0;                      // every sample loud
        1: flr = 24'hFFFFFF;              // floor saturates at one
        2: atk = '0;                      // attack ramp stalls
        3: dec = '0;                      // decay ramp stalls
        5: begin
          thr = 24'h800000;
          atk = 24'hFFFFFF;
          dec = 24'hFFFFFF;
          hld = 20'hFFFFF;
        end
        6: begin
          thr = 24'hFFFFFF;
          flr = 24'h800000;
        end
        7: begin
          atk = 24'h000001;
          dec = 24'h000001;
          flr = '0;
        end
        default: ;
      endcase
      load_set(en, thr, atk, hld, dec, flr);
      steady = (p % 3 == 2);
      k = 0;
      while (k < SET_ITEMS) begin
        kind = $urandom_range(0, 9);
        len = (kind < 2) ? $urandom_range(1, 8) :
              (kind < 6) ? $urandom_range(1, 12) : $urandom_range(1, 60);
        if (len > SET_ITEMS - k) len = SET_ITEMS - k;
        repeat (len) begin
          shot = (kind < 2) ? 24'($urandom) : (kind < 6) ? loud_sample() : quiet_sample();
          send_sample(shot);
          k++;
        end
      end
    end
    drain();

    $display("%0d samples over %0d register sets, %0d register writes",
             n_sent, SETS + 1, n_writes);
    $display("%0d gated beats checked, %0d mismatches", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("noise_gate_attack_hold_decay_unit_tb OK");
    end else begin
      $display("noise_gate_attack_hold_decay_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d beats still due", pending);
    $display("noise_gate_attack_hold_decay_unit_tb NOT OK");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ngahd_pkg.sv
rtl/ngahd_front.sv
rtl/ngahd_queue.sv
rtl/ngahd_back.sv
rtl/noise_gate_attack_hold_decay_unit.sv
test/noise_gate_attack_hold_decay_unit_checker.sv
test/noise_gate_attack_hold_decay_unit_tb.sv
